>>> rtl/core/lpht_pkg.sv
// Package: types, constants and FNV-1a hash constants for the linear probe hash table.
package lpht_pkg;

  localparam int unsigned SLOTS      = 256;
  localparam int unsigned KEY_BYTES  = 8;
  localparam int unsigned VALUE_BITS = 64;
  localparam int unsigned IDX_W      = $clog2(SLOTS);
  localparam int unsigned CNT_W      = IDX_W + 1;
  localparam int unsigned KEY_W      = 8 * KEY_BYTES;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned HASH_W     = 32;
  localparam int unsigned LIMIT      = (SLOTS * 3 + 3) / 4;

  localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
  localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

  typedef enum logic [1:0] {
    CMD_SET    = 2'd0,
    CMD_GET    = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INSERTED = 2'd1,
    ST_ABSENT   = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_PROBE_RD, S_PROBE_CHK, S_SHIFT_RD, S_SHIFT_CHK,
    S_RESP
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;        // capture request
    logic hash_step;   // one FNV round
    logic idx_home;    // probe index := home slot
    logic idx_next;    // probe index + 1
    logic rd;          // read slot at probe index
    logic wr_insert;   // write new entry at probe index
    logic wr_value;    // update value at probe index
    logic clr_occ;     // clear occupied at probe index
    logic set_hole;    // hole := probe index
    logic move;        // copy probe entry to hole, clear probe, hole := probe
    logic clr_step;    // clear occupied at clear counter
    logic cnt_inc;
    logic cnt_dec;
    logic set_status;
    status_e status;
    logic rd_hit;      // latch read value
  } ctrl_t;

  // Datapath status to controller.
  typedef struct packed {
    cmd_e cmd;
    logic hash_done;
    logic occ;
    logic hit;
    logic stays;
    logic full;
    logic clr_done;
    logic scan_done;
  } stat_t;

endpackage

>>> rtl/core/lpht_if.sv
// Valid/ready channel interfaces for requests and results.
interface lpht_req_if;
  logic                                     valid;
  logic                                     ready;
  logic [1:0]                               command;
  logic [lpht_pkg::KEY_W-1:0]               key_bytes;
  logic [lpht_pkg::LEN_W-1:0]               key_length;
  logic [lpht_pkg::VALUE_BITS-1:0]          write_value;
  modport source (output valid, command, key_bytes, key_length, write_value, input ready);
  modport sink   (input valid, command, key_bytes, key_length, write_value, output ready);
endinterface

interface lpht_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      status;
  logic [lpht_pkg::VALUE_BITS-1:0] read_value;
  logic [8:0]                      entry_count;
  modport source (output valid, status, read_value, entry_count, input ready);
  modport sink   (input valid, status, read_value, entry_count, output ready);
endinterface

>>> rtl/core/lpht_datapath.sv
// Datapath: request registers, FNV-1a unit, slot memories, probe and hole indexes.
module lpht_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [1:0]                        command_i,
  input  logic [lpht_pkg::KEY_W-1:0]        key_bytes_i,
  input  logic [lpht_pkg::LEN_W-1:0]        key_length_i,
  input  logic [lpht_pkg::VALUE_BITS-1:0]   write_value_i,
  input  lpht_pkg::ctrl_t                   ctrl_i,
  output lpht_pkg::stat_t                   stat_o,
  output logic [1:0]                        status_o,
  output logic [lpht_pkg::VALUE_BITS-1:0]   read_value_o,
  output logic [8:0]                        entry_count_o
);
  localparam int unsigned IW = lpht_pkg::IDX_W;
  localparam int unsigned KW = lpht_pkg::KEY_W;
  localparam int unsigned VW = lpht_pkg::VALUE_BITS;
  localparam int unsigned HW = lpht_pkg::HASH_W;
  localparam int unsigned LW = lpht_pkg::LEN_W;

  logic [1:0]    cmd_q;
  logic [KW-1:0] key_q;
  logic [LW-1:0] len_q;
  logic [VW-1:0] val_q;
  logic [HW-1:0] hash_q;
  logic [LW-1:0] byte_q;
  logic [IW-1:0] idx_q, hole_q;
  logic [IW:0]   clr_q, scan_q;
  logic [lpht_pkg::CNT_W-1:0] cnt_q;
  logic [1:0]    status_q;
  logic [VW-1:0] rdv_q;

  logic          occ_q [lpht_pkg::SLOTS];
  logic [KW-1:0] mkey [lpht_pkg::SLOTS];
  logic [LW-1:0] mlen [lpht_pkg::SLOTS];
  logic [HW-1:0] mhash [lpht_pkg::SLOTS];
  logic [VW-1:0] mval [lpht_pkg::SLOTS];

  logic          r_occ;
  logic [KW-1:0] r_key;
  logic [LW-1:0] r_len;
  logic [HW-1:0] r_hash;
  logic [VW-1:0] r_val;

  logic [LW-1:0] len_sat;
  logic [KW-1:0] key_mask;
  logic [IW-1:0] home, idx_p1;
  logic [7:0]    cur_byte;

  always_comb begin
    len_sat = (key_length_i > LW'(lpht_pkg::KEY_BYTES)) ? LW'(lpht_pkg::KEY_BYTES)
                                                       : key_length_i;
    key_mask = '0;
    for (int i = 0; i < int'(lpht_pkg::KEY_BYTES); i++) begin
      if (LW'(i) < len_sat) key_mask[8*i +: 8] = 8'hff;
    end
    cur_byte = key_q[{byte_q[2:0], 3'b000} +: 8];
    home   = r_hash[IW-1:0];
    idx_p1 = idx_q + IW'(1);
  end

  // Request capture, hash rounds, indexes, counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      clr_q  <= '0;
      cmd_q  <= '0;
    end else begin
      if (ctrl_i.load) begin
        cmd_q  <= command_i;
        key_q  <= key_bytes_i & key_mask;
        len_q  <= len_sat;
        val_q  <= write_value_i;
        hash_q <= lpht_pkg::FNV_BASIS;
        byte_q <= '0;
        rdv_q  <= '0;
      end
      if (ctrl_i.hash_step) begin
        hash_q <= (hash_q ^ {24'd0, cur_byte}) * lpht_pkg::FNV_PRIME;
        byte_q <= byte_q + LW'(1);
      end
      if (ctrl_i.idx_home) begin
        idx_q  <= hash_q[IW-1:0];
        scan_q <= '0;
      end
      if (ctrl_i.set_hole) begin
        hole_q <= idx_q;
        idx_q  <= idx_p1;
        scan_q <= '0;
      end else if (ctrl_i.move) begin
        hole_q <= idx_q;
        idx_q  <= idx_p1;
        scan_q <= scan_q + (IW+1)'(1);
      end else if (ctrl_i.idx_next) begin
        idx_q  <= idx_p1;
        scan_q <= scan_q + (IW+1)'(1);
      end
      if (ctrl_i.clr_step) clr_q <= clr_q + (IW+1)'(1);
      if (ctrl_i.cnt_inc) cnt_q <= cnt_q + lpht_pkg::CNT_W'(1);
      if (ctrl_i.cnt_dec) cnt_q <= cnt_q - lpht_pkg::CNT_W'(1);
      if (ctrl_i.set_status) status_q <= ctrl_i.status;
      if (ctrl_i.rd_hit) rdv_q <= r_val;
    end
  end

  // Occupied marks live in flops; cleared by a sweep after reset.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr_step) occ_q[clr_q[IW-1:0]] <= 1'b0;
    if (ctrl_i.wr_insert) occ_q[idx_q] <= 1'b1;
    if (ctrl_i.clr_occ) occ_q[idx_q] <= 1'b0;
    if (ctrl_i.move) begin
      occ_q[hole_q] <= 1'b1;
      occ_q[idx_q]  <= 1'b0;
    end
    if (ctrl_i.rd) r_occ <= occ_q[idx_q];
  end

  // Slot payload memory: one write, one registered read.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_insert) begin
      mkey[idx_q]  <= key_q;
      mlen[idx_q]  <= len_q;
      mhash[idx_q] <= hash_q;
      mval[idx_q]  <= val_q;
    end else if (ctrl_i.wr_value) begin
      mval[idx_q] <= val_q;
    end else if (ctrl_i.move) begin
      mkey[hole_q]  <= r_key;
      mlen[hole_q]  <= r_len;
      mhash[hole_q] <= r_hash;
      mval[hole_q]  <= r_val;
    end
    if (ctrl_i.rd) begin
      r_key  <= mkey[idx_q];
      r_len  <= mlen[idx_q];
      r_hash <= mhash[idx_q];
      r_val  <= mval[idx_q];
    end
  end

  // During the shift check idx_q is the slot just read and hole_q the open slot.
  logic stays;
  always_comb begin
    if (idx_q > hole_q) stays = (home > hole_q) && (home <= idx_q);
    else                stays = (home > hole_q) || (home <= idx_q);
  end

  assign stat_o.cmd       = lpht_pkg::cmd_e'(cmd_q);
  assign stat_o.hash_done = (byte_q == len_q);
  assign stat_o.occ       = r_occ;
  assign stat_o.hit       = r_occ && (r_hash == hash_q) && (r_len == len_q) && (r_key == key_q);
  assign stat_o.stays     = stays;
  assign stat_o.full      = (cnt_q >= lpht_pkg::CNT_W'(lpht_pkg::LIMIT));
  assign stat_o.clr_done  = clr_q[IW];
  assign stat_o.scan_done = scan_q[IW];

  assign status_o      = status_q;
  assign read_value_o  = rdv_q;
  assign entry_count_o = 9'(cnt_q);
endmodule

>>> rtl/core/lpht_ctrl.sv
// Controller: sequences hashing, probing, insert/update and backward-shift delete.
module lpht_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  output logic            rsp_valid_o,
  input  logic            rsp_ready_i,
  input  lpht_pkg::stat_t stat_i,
  output lpht_pkg::ctrl_t ctrl_o
);
  lpht_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= lpht_pkg::S_CLEAR;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d     = state_q;
    ctrl_o      = '0;
    ctrl_o.status = lpht_pkg::ST_ABSENT;
    req_ready_o = 1'b0;
    rsp_valid_o = 1'b0;
    case (state_q)
      lpht_pkg::S_CLEAR: begin
        ctrl_o.clr_step = 1'b1;
        if (stat_i.clr_done) begin
          ctrl_o.clr_step = 1'b0;
          state_d = lpht_pkg::S_IDLE;
        end
      end
      lpht_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d = lpht_pkg::S_HASH;
        end
      end
      lpht_pkg::S_HASH: begin
        if (stat_i.hash_done) begin
          ctrl_o.idx_home = 1'b1;
          if (stat_i.cmd == lpht_pkg::CMD_NONE) begin
            ctrl_o.set_status = 1'b1;
            state_d = lpht_pkg::S_RESP;
          end else begin
            state_d = lpht_pkg::S_PROBE_RD;
          end
        end else begin
          ctrl_o.hash_step = 1'b1;
        end
      end
      lpht_pkg::S_PROBE_RD: begin
        ctrl_o.rd = 1'b1;
        state_d = lpht_pkg::S_PROBE_CHK;
      end
      lpht_pkg::S_PROBE_CHK: begin
        ctrl_o.set_status = 1'b1;
        state_d = lpht_pkg::S_RESP;
        if (stat_i.hit) begin
          ctrl_o.status = lpht_pkg::ST_OK;
          case (stat_i.cmd)
            lpht_pkg::CMD_SET: ctrl_o.wr_value = 1'b1;
            lpht_pkg::CMD_GET: ctrl_o.rd_hit = 1'b1;
            lpht_pkg::CMD_DELETE: begin
              ctrl_o.clr_occ  = 1'b1;
              ctrl_o.cnt_dec  = 1'b1;
              ctrl_o.set_hole = 1'b1;
              state_d = lpht_pkg::S_SHIFT_RD;
            end
            default: ;
          endcase
        end else if (!stat_i.occ) begin
          if (stat_i.cmd == lpht_pkg::CMD_SET) begin
            if (stat_i.full) begin
              ctrl_o.status = lpht_pkg::ST_FULL;
            end else begin
              ctrl_o.status    = lpht_pkg::ST_INSERTED;
              ctrl_o.wr_insert = 1'b1;
              ctrl_o.cnt_inc   = 1'b1;
            end
          end
        end else begin
          ctrl_o.set_status = 1'b0;
          ctrl_o.idx_next = 1'b1;
          state_d = lpht_pkg::S_PROBE_RD;
        end
      end
      lpht_pkg::S_SHIFT_RD: begin
        ctrl_o.rd = 1'b1;
        state_d = lpht_pkg::S_SHIFT_CHK;
      end
      lpht_pkg::S_SHIFT_CHK: begin
        if (!stat_i.occ || stat_i.scan_done) begin
          state_d = lpht_pkg::S_RESP;
        end else begin
          if (stat_i.stays) ctrl_o.idx_next = 1'b1;
          else              ctrl_o.move = 1'b1;
          state_d = lpht_pkg::S_SHIFT_RD;
        end
      end
      lpht_pkg::S_RESP: begin
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) state_d = lpht_pkg::S_IDLE;
      end
      default: state_d = lpht_pkg::S_IDLE;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.cnt_inc |-> !ctrl_o.cnt_dec)) else $error("count inc and dec together");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.wr_insert |-> !stat_i.full)) else $error("insert into full table");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_ready_o |-> !rsp_valid_o)) else $error("ready while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.load |=> state_q == lpht_pkg::S_HASH)) else $error("load did not start hash");
endmodule

>>> rtl/core/linear_probe_hash_table.sv
// Top level: key-value hash table with linear probing and FNV-1a slot hashing.
//
//  channel  dir  fields
//  req      in   command, key_bytes, key_length, write_value
//  rsp      out  status, read_value, entry_count
//
// After reset a sweep clears the occupied marks, one slot a cycle, with req.ready low.
// After the accepting edge a request runs one FNV round per key byte (key_length,
// capped at 8), then seeds the probe at its home slot; each probed slot is read and
// then checked, and for delete each slot walked by the backward shift likewise; the
// block then waits in the result state until rsp.ready. One request at a time.
module linear_probe_hash_table (
  input  logic       clk_i,
  input  logic       rst_ni,
  lpht_req_if.sink   req,
  lpht_rsp_if.source rsp
);
  lpht_pkg::ctrl_t ctrl;
  lpht_pkg::stat_t stat;

  lpht_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .rsp_valid_o (rsp.valid),
    .rsp_ready_i (rsp.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  lpht_datapath u_dp (
    .clk_i, .rst_ni,
    .command_i     (req.command),
    .key_bytes_i   (req.key_bytes),
    .key_length_i  (req.key_length),
    .write_value_i (req.write_value),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .status_o      (rsp.status),
    .read_value_o  (rsp.read_value),
    .entry_count_o (rsp.entry_count)
  );
endmodule

>>> dv/tb_linear_probe_hash_table.sv
// Testbench for the linear probe hash table: directed table plus random traffic vs. predictor.
`timescale 1ns / 1ps

module tb_linear_probe_hash_table;

  localparam int unsigned WATCHDOG_CYCLES = 20000;

  typedef struct {
    lpht_pkg::cmd_e    command;
    logic [63:0]       key;
    logic [3:0]        len;
    logic [63:0]       wval;
    bit                has_fixed;
    lpht_pkg::status_e fx_status;
    logic [63:0]       fx_value;
    logic [8:0]        fx_count;
  } request_t;

  typedef struct {
    lpht_pkg::status_e status;
    logic [63:0]       value;
    logic [8:0]        count;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lpht_req_if req ();
  lpht_rsp_if rsp ();

  linear_probe_hash_table uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req.sink),
    .rsp    (rsp.source)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow table of the block.
  bit          tbl_occ  [lpht_pkg::SLOTS];
  logic [63:0] tbl_key  [lpht_pkg::SLOTS];
  logic [3:0]  tbl_len  [lpht_pkg::SLOTS];
  logic [31:0] tbl_hash [lpht_pkg::SLOTS];
  logic [63:0] tbl_val  [lpht_pkg::SLOTS];
  int unsigned tbl_count;

  answer_t     pending_answers[$];
  logic [63:0] known_keys[$];
  logic [3:0]  known_lens[$];

  int unsigned errors = 0;
  int unsigned answers_seen = 0;
  int unsigned req_sent = 0;
  int unsigned n_full = 0, n_hit_del = 0;
  int unsigned idle_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          long_hold = 1'b0;
  bit          done = 1'b0;

  function automatic logic [31:0] fnv_hash(logic [63:0] key, logic [3:0] len);
    logic [31:0] h;
    h = lpht_pkg::FNV_BASIS;
    for (int i = 0; i < len; i++) begin
      h = (h ^ {24'd0, key[8*i +: 8]}) * lpht_pkg::FNV_PRIME;
    end
    return h;
  endfunction

  function automatic answer_t table_apply(lpht_pkg::cmd_e command, logic [63:0] key_in,
                                          logic [3:0] len_in, logic [63:0] wval);
    answer_t     a;
    logic [3:0]  len;
    logic [63:0] key;
    logic [31:0] h;
    int unsigned idx, hole, home, nxt;
    bit          hit, stays;
    len = (len_in > lpht_pkg::KEY_BYTES) ? 4'(lpht_pkg::KEY_BYTES) : len_in;
    key = (len == 0) ? 64'd0 : key_in & (~64'd0 >> (64 - 8 * len));
    h = fnv_hash(key, len);
    a.status = lpht_pkg::ST_ABSENT;
    a.value = '0;
    hit = 1'b0;
    idx = h % lpht_pkg::SLOTS;
    for (int n = 0; n < lpht_pkg::SLOTS; n++) begin
      if (!tbl_occ[idx]) break;
      if (tbl_hash[idx] == h && tbl_len[idx] == len && tbl_key[idx] == key) begin
        hit = 1'b1;
        break;
      end
      idx = (idx + 1) % lpht_pkg::SLOTS;
    end
    case (command)
      lpht_pkg::CMD_SET: begin
        if (hit) begin
          tbl_val[idx] = wval;
          a.status = lpht_pkg::ST_OK;
        end else if (tbl_count * 4 >= lpht_pkg::SLOTS * 3) begin
          a.status = lpht_pkg::ST_FULL;
          n_full++;
        end else begin
          tbl_occ[idx] = 1'b1;
          tbl_key[idx] = key;
          tbl_len[idx] = len;
          tbl_hash[idx] = h;
          tbl_val[idx] = wval;
          tbl_count++;
          a.status = lpht_pkg::ST_INSERTED;
        end
      end
      lpht_pkg::CMD_GET: begin
        if (hit) begin
          a.value = tbl_val[idx];
          a.status = lpht_pkg::ST_OK;
        end
      end
      lpht_pkg::CMD_DELETE: begin
        if (hit) begin
          a.status = lpht_pkg::ST_OK;
          n_hit_del++;
          // Backward-shift repair of the probe chain.
          hole = idx;
          tbl_occ[hole] = 1'b0;
          tbl_count--;
          nxt = (hole + 1) % lpht_pkg::SLOTS;
          for (int n = 0; n < lpht_pkg::SLOTS && tbl_occ[nxt]; n++) begin
            home = tbl_hash[nxt] % lpht_pkg::SLOTS;
            if (nxt > hole) stays = home > hole && home <= nxt;
            else stays = home > hole || home <= nxt;
            if (!stays) begin
              tbl_occ[hole] = 1'b1;
              tbl_key[hole] = tbl_key[nxt];
              tbl_len[hole] = tbl_len[nxt];
              tbl_hash[hole] = tbl_hash[nxt];
              tbl_val[hole] = tbl_val[nxt];
              tbl_occ[nxt] = 1'b0;
              hole = nxt;
            end
            nxt = (nxt + 1) % lpht_pkg::SLOTS;
          end
        end
      end
      default: ;
    endcase
    a.count = 9'(tbl_count);
    return a;
  endfunction

  // Offer one request from a falling edge and return at the falling edge after it is taken.
  task automatic send_request(request_t r);
    answer_t a;
    while (!long_hold && ($urandom_range(99) < send_idle_pct)) begin
      req.valid <= 1'b0;
      @(negedge clk_i);
    end
    req.valid       <= 1'b1;
    req.command     <= r.command;
    req.key_bytes   <= r.key;
    req.key_length  <= r.len;
    req.write_value <= r.wval;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    a = table_apply(r.command, r.key, r.len, r.wval);
    if (r.has_fixed && (a.status != r.fx_status || a.value != r.fx_value ||
                        a.count != r.fx_count)) begin
      $display("%0t directed row %0d: table expects %s/%h/%0d, row %s/%h/%0d", $time,
               req_sent, a.status.name(), a.value, a.count, r.fx_status.name(),
               r.fx_value, r.fx_count);
      errors++;
    end
    pending_answers.push_back(a);
    if (r.command == lpht_pkg::CMD_SET && a.status == lpht_pkg::ST_INSERTED) begin
      known_keys.push_back(r.key);
      known_lens.push_back(r.len);
    end
    req_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk_i);
  endtask

  function automatic request_t make_row(lpht_pkg::cmd_e c, logic [63:0] k, logic [3:0] l,
                                        logic [63:0] v, bit fx = 1'b0,
                                        lpht_pkg::status_e s = lpht_pkg::ST_OK,
                                        logic [63:0] rv = '0, logic [8:0] n = '0);
    request_t r;
    r.command = c; r.key = k; r.len = l; r.wval = v;
    r.has_fixed = fx; r.fx_status = s; r.fx_value = rv; r.fx_count = n;
    return r;
  endfunction

  function automatic request_t random_request(int unsigned set_pct);
    request_t    r;
    int unsigned pick, sel;
    pick = $urandom_range(99);
    if (pick < set_pct) r.command = lpht_pkg::CMD_SET;
    else if (pick < set_pct + (100 - set_pct) / 2) r.command = lpht_pkg::CMD_GET;
    else if (pick < 97) r.command = lpht_pkg::CMD_DELETE;
    else r.command = lpht_pkg::CMD_NONE;
    r.wval = {$urandom, $urandom};
    if (known_keys.size() != 0 && $urandom_range(99) < 60) begin
      sel = $urandom_range(known_keys.size() - 1);
      r.key = known_keys[sel];
      r.len = known_lens[sel];
      // Dirty the bytes beyond the length: they must be ignored.
      if (r.len < 8 && $urandom_range(1)) r.key |= {$urandom, $urandom} << (8 * r.len);
    end else begin
      r.len = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
      r.key = {$urandom, $urandom};
      // Narrow key space so collisions and repeats happen.
      if ($urandom_range(1)) r.key = r.key & 64'h0303_0303_0303_0303;
    end
    r.has_fixed = 1'b0;
    return r;
  endfunction

  // Result side: stalls and check against the oldest expectation.
  initial begin
    int unsigned hold;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        hold = 0;
        rsp.ready <= 1'b0;
        while (hold < 400) begin
          @(negedge clk_i);
          hold++;
        end
        long_hold = 1'b0;
      end
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    answer_t exp_a;
    if (rst_ni && rsp.valid && rsp.ready) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        $display("%0t unexpected result: status %0d value %h count %0d", $time,
                 rsp.status, rsp.read_value, rsp.entry_count);
        errors++;
      end else begin
        exp_a = pending_answers.pop_front();
        if (rsp.status !== exp_a.status || rsp.read_value !== exp_a.value ||
            rsp.entry_count !== exp_a.count) begin
          $display("%0t mismatch: expected status %0d value %h count %0d, got %0d %h %0d",
                   $time, exp_a.status, exp_a.value, exp_a.count, rsp.status,
                   rsp.read_value, rsp.entry_count);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no request or result moving.
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (!done && idle_cycles >= WATCHDOG_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    request_t directed[$];
    int unsigned limits[4][2];
    int unsigned s;
    tbl_count = 0;
    foreach (tbl_occ[i]) tbl_occ[i] = 1'b0;
    req.valid = 1'b0;
    req.command = lpht_pkg::CMD_SET;
    req.key_bytes = '0;
    req.key_length = '0;
    req.write_value = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    directed.push_back(make_row(lpht_pkg::CMD_GET, 64'h1, 4'd1, '0,
                                1, lpht_pkg::ST_ABSENT, '0, 9'd0));
    directed.push_back(make_row(lpht_pkg::CMD_DELETE, 64'h1, 4'd1, '0,
                                1, lpht_pkg::ST_ABSENT, '0, 9'd0));
    directed.push_back(make_row(lpht_pkg::CMD_SET, '0, 4'd0, ~64'd0,
                                1, lpht_pkg::ST_INSERTED, '0, 9'd1));
    directed.push_back(make_row(lpht_pkg::CMD_GET, ~64'd0, 4'd0, '0,
                                1, lpht_pkg::ST_OK, ~64'd0, 9'd1));
    directed.push_back(make_row(lpht_pkg::CMD_SET, ~64'd0, 4'd8, 64'h0,
                                1, lpht_pkg::ST_INSERTED, '0, 9'd2));
    directed.push_back(make_row(lpht_pkg::CMD_GET, ~64'd0, 4'd15, '0,
                                1, lpht_pkg::ST_OK, 64'h0, 9'd2));
    directed.push_back(make_row(lpht_pkg::CMD_SET, 64'h00, 4'd1, 64'h55,
                                1, lpht_pkg::ST_INSERTED, '0, 9'd3));
    directed.push_back(make_row(lpht_pkg::CMD_SET, 64'h0000, 4'd2, 64'hAA,
                                1, lpht_pkg::ST_INSERTED, '0, 9'd4));
    directed.push_back(make_row(lpht_pkg::CMD_GET, 64'hFF00, 4'd1, '0,
                                1, lpht_pkg::ST_OK, 64'h55, 9'd4));
    directed.push_back(make_row(lpht_pkg::CMD_SET, 64'hFF00, 4'd1, 64'h66,
                                1, lpht_pkg::ST_OK, '0, 9'd4));
    directed.push_back(make_row(lpht_pkg::CMD_NONE, 64'h00, 4'd1, 64'h1,
                                1, lpht_pkg::ST_ABSENT, '0, 9'd4));
    directed.push_back(make_row(lpht_pkg::CMD_GET, 64'h00, 4'd1, '0,
                                1, lpht_pkg::ST_OK, 64'h66, 9'd4));
    directed.push_back(make_row(lpht_pkg::CMD_DELETE, 64'h0, 4'd0, '0,
                                1, lpht_pkg::ST_OK, '0, 9'd3));
    directed.push_back(make_row(lpht_pkg::CMD_GET, 64'h0, 4'd0, '0,
                                1, lpht_pkg::ST_ABSENT, '0, 9'd3));
    directed.push_back(make_row(lpht_pkg::CMD_SET, 64'h8000_0000_0000_0001, 4'd8,
                                64'h1234));
    directed.push_back(make_row(lpht_pkg::CMD_DELETE, ~64'd0, 4'd8, '0,
                                1, lpht_pkg::ST_OK, '0, 9'd3));
    directed.push_back(make_row(lpht_pkg::CMD_DELETE, 64'h0000, 4'd2, '0,
                                1, lpht_pkg::ST_OK, '0, 9'd2));
    directed.push_back(make_row(lpht_pkg::CMD_DELETE, 64'h00, 4'd1, '0,
                                1, lpht_pkg::ST_OK, '0, 9'd1));
    directed.push_back(make_row(lpht_pkg::CMD_GET, 64'h8000_0000_0000_0001, 4'd9, '0));
    directed.push_back(make_row(lpht_pkg::CMD_DELETE, 64'h8000_0000_0000_0001, 4'd8, '0));
    foreach (directed[i]) send_request(directed[i]);
    wait_drained();

    // Sender idle and receiver stall percentages per phase.
    limits = '{'{0, 0}, '{55, 0}, '{0, 55}, '{29, 29}};
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = limits[ph][0];
      recv_stall_pct = limits[ph][1];
      if (ph == 2) long_hold = 1'b1;
      for (int i = 0; i < 45; i++) send_request(random_request(ph == 1 ? 45 : 70));
      wait_drained();
    end

    // Fill to the refusal limit with fresh keys, churn, then delete every entry.
    send_idle_pct = 0;
    recv_stall_pct = 20;
    while (tbl_count < lpht_pkg::LIMIT) begin
      send_request(make_row(lpht_pkg::CMD_SET, {$urandom, $urandom}, 4'd8,
                            {$urandom, $urandom}));
    end
    for (int i = 0; i < 20; i++) send_request(random_request(60));
    while (tbl_count != 0) begin
      s = 0;
      while (!tbl_occ[s]) s++;
      send_request(make_row(lpht_pkg::CMD_DELETE, tbl_key[s], tbl_len[s], '0));
    end
    wait_drained();
    repeat (50) @(negedge clk_i);
    done = 1'b1;

    $display("Covered %0d requests, %0d results, %0d refused sets, %0d chain deletes.",
             req_sent, answers_seen, n_full, n_hit_del);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
